### hw/rtl/lms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_pkg
// Types, widths and codes shared by the local minimum search block.
// ----------------------------------------------------------------------------
package lms_pkg;

   // Field widths of the channels and the count register
   localparam int FIELD_W = 13;
   localparam int VAL_W   = 13;
   localparam int CNT_W   = 13;

   // Internal positions carry one extra bit so that middle+1 never wraps
   localparam int POS_W = FIELD_W + 1;

   // Search epoch tag kept next to every stored value
   localparam int EPOCH_W = 8;

   // Default largest supported permutation length
   localparam int LMS_MAX_COUNT = 4096;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_COUNT = 1'b0;

   // Input action codes
   localparam logic ACTION_START  = 1'b0;
   localparam logic ACTION_ANSWER = 1'b1;

   // Result kind codes
   localparam logic KIND_QUERY = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   // Infinite value for positions outside 1..count
   localparam logic [VAL_W:0] VAL_INF = {1'b1, {VAL_W{1'b0}}};

   // Search phase
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_MID   = 2'd1,
      PH_RIGHT = 2'd2,
      PH_LEFT  = 2'd3
   } phase_type;

   // Result handed from the search engine to the output register
   typedef struct packed {
      logic               valid;
      logic               kind;
      logic [FIELD_W-1:0] index;
   } result_type;

endpackage

### hw/rtl/lms_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_req_if
// Input channel: start and answer transactions.
// ----------------------------------------------------------------------------
interface lms_req_if import lms_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               action;
   logic [VAL_W-1:0]   value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

### hw/rtl/lms_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_rsp_if
// Result channel: query requests and final answers.
// ----------------------------------------------------------------------------
interface lms_rsp_if import lms_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [FIELD_W-1:0] index;

   modport source (output valid, output kind, output index, input ready);
   modport sink   (input valid, input kind, input index, output ready);
endinterface

### hw/rtl/lms_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en_a,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [WIDTH-1:0]  rd_data_a,
   input  logic              rd_en_b,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_data_a_ff <= mem[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

### hw/rtl/lms_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lms_core
// Search engine: bounds, phase, epoch-tagged value store and the sequencer
// that evaluates each transaction and prefetches the midpoint's neighbors.
// ----------------------------------------------------------------------------
module lms_core import lms_pkg::*; #(
   parameter int MAX_COUNT = LMS_MAX_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] count,
   lms_req_if.sink          req,
   output result_type       res,
   input  logic             res_ready
);

   localparam int DEPTH  = MAX_COUNT + 2;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int MEM_W  = EPOCH_W + VAL_W;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_EVAL  = 4'b0100,
      S_ROUND = 4'b1000
   } state_type;

   // Control registers
   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   lower_ff, lower_in;
   logic [POS_W-1:0]   upper_ff, upper_in;
   logic [POS_W-1:0]   middle_ff, middle_in;
   logic [POS_W-1:0]   pending_ff, pending_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic               pf_ff, pf_in;
   logic               resume_ff, resume_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;

   // Payload registers
   logic               act_ff, act_in;
   logic [VAL_W-1:0]   v_mid_ff, v_mid_in;
   logic [VAL_W-1:0]   nb_left_ff, nb_left_in;
   logic [VAL_W-1:0]   nb_right_ff, nb_right_in;

   // Memory ports
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [MEM_W-1:0]   wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr_l;
   logic [ADDR_W-1:0]  rd_addr_r;
   logic [MEM_W-1:0]   rd_data_l;
   logic [MEM_W-1:0]   rd_data_r;

   // Datapath
   logic               accept;
   logic               wr_acc;
   logic [POS_W-1:0]   eff_n;
   logic [POS_W-1:0]   pos_r;
   logic [POS_W-1:0]   pos_l;
   logic               unk_r;
   logic               unk_l;
   logic [VAL_W:0]     vm;
   logic [VAL_W:0]     vl;
   logic [VAL_W:0]     vr;
   logic [POS_W:0]     sum_lu;
   logic [POS_W-1:0]   mid;
   logic               go;

   lms_ram #(
      .WIDTH (MEM_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en_a   (rd_en),
      .rd_addr_a (rd_addr_l),
      .rd_data_a (rd_data_l),
      .rd_en_b   (rd_en),
      .rd_addr_b (rd_addr_r),
      .rd_data_b (rd_data_r)
   );

   // Take a transaction only between evaluations
   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && (state_ff == S_IDLE);
   assign wr_acc    = accept && (req.action == ACTION_ANSWER) && (phase_ff != PH_IDLE);

   // Store write: clearing sweep or the answer to the pending query
   always_comb begin
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = wr_acc;
         wr_addr = ADDR_W'(pending_ff);
         wr_data = {epoch_ff, req.value};
      end
   end

   // Clip count to the supported size
   always_comb begin
      if (32'(count) > 32'(MAX_COUNT)) begin
         eff_n = POS_W'(MAX_COUNT);
      end else begin
         eff_n = POS_W'(count);
      end
   end

   // Neighbor tests and values with infinite edges
   assign pos_r = middle_ff + POS_W'(1);
   assign pos_l = middle_ff - POS_W'(1);
   assign unk_r = (pos_r <= eff_n) && (nb_right_ff == '0);
   assign unk_l = (pos_l != '0) && (pos_l <= eff_n) && (nb_left_ff == '0);
   assign vm = ((middle_ff != '0) && (middle_ff <= eff_n)) ? {1'b0, v_mid_ff} : VAL_INF;
   assign vl = ((pos_l != '0) && (pos_l <= eff_n)) ? {1'b0, nb_left_ff} : VAL_INF;
   assign vr = (pos_r <= eff_n) ? {1'b0, nb_right_ff} : VAL_INF;

   // Next midpoint and its neighbor addresses
   assign sum_lu    = {1'b0, lower_ff} + {1'b0, upper_ff};
   assign mid       = sum_lu[POS_W:1];
   assign rd_addr_l = ADDR_W'(mid - POS_W'(1));
   assign rd_addr_r = ADDR_W'(mid + POS_W'(1));

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      lower_in    = lower_ff;
      upper_in    = upper_ff;
      middle_in   = middle_ff;
      pending_in  = pending_ff;
      epoch_in    = epoch_ff;
      pf_in       = 1'b0;
      resume_in   = resume_ff;
      clr_addr_in = clr_addr_ff;
      act_in      = act_ff;
      v_mid_in    = v_mid_ff;
      nb_left_in  = nb_left_ff;
      nb_right_in = nb_right_ff;
      res.valid   = 1'b0;
      res.kind    = KIND_QUERY;
      res.index   = '0;
      rd_en       = 1'b0;
      go          = 1'b1;

      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in  = resume_ff ? S_EVAL : S_IDLE;
               resume_in = 1'b0;
            end
         end

         S_IDLE: begin
            // Capture prefetched neighbors, stale epochs read as unknown
            if (pf_ff) begin
               nb_left_in  = (rd_data_l[MEM_W-1:VAL_W] == epoch_ff) ?
                             rd_data_l[VAL_W-1:0] : '0;
               nb_right_in = (rd_data_r[MEM_W-1:VAL_W] == epoch_ff) ?
                             rd_data_r[VAL_W-1:0] : '0;
            end
            if (accept) begin
               act_in   = req.action;
               state_in = S_EVAL;
               if (wr_acc) begin
                  case (phase_ff)
                     PH_MID:   v_mid_in    = req.value;
                     PH_RIGHT: nb_right_in = req.value;
                     PH_LEFT:  nb_left_in  = req.value;
                     default:  v_mid_in    = v_mid_ff;
                  endcase
               end
            end
         end

         S_EVAL: begin
            if (act_ff == ACTION_START) begin
               if (epoch_ff == '1) begin
                  // Tags about to wrap: sweep the store, then retry the start
                  epoch_in    = '0;
                  resume_in   = 1'b1;
                  clr_addr_in = '0;
                  state_in    = S_CLEAR;
               end else begin
                  if (eff_n <= POS_W'(1)) begin
                     res.valid = 1'b1;
                     res.kind  = KIND_FINAL;
                     res.index = FIELD_W'(eff_n);
                  end
                  go = !res.valid || res_ready;
                  if (go) begin
                     epoch_in   = epoch_ff + EPOCH_W'(1);
                     lower_in   = POS_W'(1);
                     upper_in   = eff_n;
                     middle_in  = '0;
                     pending_in = '0;
                     phase_in   = PH_IDLE;
                     state_in   = res.valid ? S_IDLE : S_ROUND;
                  end
               end
            end else if (phase_ff == PH_IDLE) begin
               // Stray answer
               res.valid = 1'b1;
               res.kind  = KIND_FINAL;
               res.index = '0;
               go = res_ready;
               if (go) begin
                  state_in = S_IDLE;
               end
            end else if ((phase_ff == PH_MID) && unk_r) begin
               res.valid = 1'b1;
               res.kind  = KIND_QUERY;
               res.index = FIELD_W'(pos_r);
               go = res_ready;
               if (go) begin
                  phase_in   = PH_RIGHT;
                  pending_in = pos_r;
                  state_in   = S_IDLE;
               end
            end else if ((phase_ff != PH_LEFT) && unk_l) begin
               res.valid = 1'b1;
               res.kind  = KIND_QUERY;
               res.index = FIELD_W'(pos_l);
               go = res_ready;
               if (go) begin
                  phase_in   = PH_LEFT;
                  pending_in = pos_l;
                  state_in   = S_IDLE;
               end
            end else if ((vm < vr) && (vm < vl)) begin
               res.valid = 1'b1;
               res.kind  = KIND_FINAL;
               res.index = FIELD_W'(middle_ff);
               go = res_ready;
               if (go) begin
                  phase_in = PH_IDLE;
                  state_in = S_IDLE;
               end
            end else begin
               // Narrow toward the smaller neighbor, equal values keep the range
               if (vl < vm) begin
                  upper_in = pos_l;
               end else if (vr < vm) begin
                  lower_in = pos_r;
               end
               state_in = S_ROUND;
            end
         end

         S_ROUND: begin
            res.valid = 1'b1;
            if (lower_ff > upper_ff) begin
               res.kind  = KIND_FINAL;
               res.index = '0;
               go = res_ready;
               if (go) begin
                  phase_in = PH_IDLE;
                  state_in = S_IDLE;
               end
            end else begin
               res.kind  = KIND_QUERY;
               res.index = FIELD_W'(mid);
               go = res_ready;
               if (go) begin
                  rd_en      = 1'b1;
                  pf_in      = 1'b1;
                  middle_in  = mid;
                  pending_in = mid;
                  phase_in   = PH_MID;
                  state_in   = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         phase_ff    <= PH_IDLE;
         lower_ff    <= POS_W'(1);
         upper_ff    <= '0;
         middle_ff   <= '0;
         pending_ff  <= '0;
         epoch_ff    <= '0;
         pf_ff       <= 1'b0;
         resume_ff   <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         lower_ff    <= lower_in;
         upper_ff    <= upper_in;
         middle_ff   <= middle_in;
         pending_ff  <= pending_in;
         epoch_ff    <= epoch_in;
         pf_ff       <= pf_in;
         resume_ff   <= resume_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Transaction payload and local copies of the current round's values
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      v_mid_ff    <= v_mid_in;
      nb_left_ff  <= nb_left_in;
      nb_right_ff <= nb_right_in;
   end

   // A live search always has its midpoint inside the bounds
   a_mid_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && phase_ff != PH_IDLE) |->
      (middle_ff >= lower_ff && middle_ff <= upper_ff))
      else $error("midpoint outside search bounds");

   // Pending right query is the midpoint's right neighbor
   a_pending_right: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RIGHT) |-> (pending_ff == POS_W'(middle_ff + POS_W'(1))))
      else $error("pending index is not middle+1");

   // Pending left query is the midpoint's left neighbor
   a_pending_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEFT) |-> (pending_ff == POS_W'(middle_ff - POS_W'(1))))
      else $error("pending index is not middle-1");

   // Prefetch data is captured in the cycle right after the read
   a_prefetch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && rd_en) |=> (state_ff == S_IDLE && pf_ff))
      else $error("neighbor prefetch not followed by capture");

endmodule

### hw/rtl/local_minimum_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_minimum_search
// Interactive local minimum search over a permutation held by a partner.
// ----------------------------------------------------------------------------
//
//  Channel    Ports       Direction  Carries
//  request    req_chan    in         action (start / answer), value
//  response   rsp_chan    out        kind (query / final), index
//  config     p*          in/out     APB-style, register count at byte 0
//
//  A transaction answered straight from its evaluation uses S_EVAL alone; a
//  start or an answer that opens a new round also passes S_ROUND, which
//  issues the two-port store read of the midpoint's neighbors. After reset
//  the store is swept once over all MAX_COUNT+2 entries, req_chan not ready;
//  the 256th start and every 255th after it redo it when the epoch wraps.
//  A response left waiting holds the next evaluation and req_chan with it.
//
module local_minimum_search import lms_pkg::*; #(
   parameter int MAX_COUNT = LMS_MAX_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   lms_req_if.sink               req_chan,
   lms_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [FIELD_W-1:0] rsp_index_ff, rsp_index_in;
   logic               csr_wr;
   logic               out_free;
   result_type         res;

   // Configuration register
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[CSR_ADDR_W-1:2] == REG_COUNT);
   assign count_in = csr_wr ? pwdata[CNT_W-1:0] : count_ff;
   assign prdata = (paddr[CSR_ADDR_W-1:2] == REG_COUNT) ? CSR_DATA_W'(count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(1);
      end else begin
         count_ff <= count_in;
      end
   end

   lms_core #(
      .MAX_COUNT (MAX_COUNT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .count     (count_ff),
      .req       (req_chan),
      .res       (res),
      .res_ready (out_free)
   );

   // Output register: load when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_index_in = rsp_index_ff;
      if (out_free) begin
         rsp_valid_in = res.valid;
         if (res.valid) begin
            rsp_kind_in  = res.kind;
            rsp_index_in = res.index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kind  = rsp_kind_ff;
   assign rsp_chan.index = rsp_index_ff;

endmodule
